// ===== hw/rtl/event_corner_tracker_unit_defines.svh =====
// Assertion macros for the corner tracker.
`ifndef EVENT_CORNER_TRACKER_UNIT_DEFINES_SVH
`define EVENT_CORNER_TRACKER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ECT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ECT_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ECT_ASSERT(label, clk, rst_n, prop, msg)
`define ECT_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/ect_pkg.sv =====
`default_nettype none
package ect_pkg;
    localparam int unsigned CoordW = 10;
    localparam int unsigned LimitW = 20;
    localparam int unsigned GainW  = 16;
    localparam int unsigned OpW    = 2;
    localparam int unsigned SqW    = 21;

    localparam logic [OpW-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OpW-1:0] OP_APPEND = 2'd1;
    localparam logic [OpW-1:0] OP_EVENT  = 2'd2;

    localparam logic [SqW-1:0] SEARCH_START_SQ = 21'd1000000;
    localparam logic [CoordW-1:0] COORD_MAX = 10'd1023;

    localparam logic REG_LIMIT = 1'b0;
    localparam logic REG_GAIN  = 1'b1;

    typedef logic [CoordW-1:0] t_coord;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } t_div_req;
endpackage
`default_nettype wire

// ===== hw/rtl/event_corner_tracker_unit.sv =====
`default_nettype none
// Event corner tracker.
// Command channel: drive i_op, i_pos_x, i_pos_y with i_start high while
// o_busy is low; the word is taken at that edge. One result word per
// command appears on the o_* fields, held until the next, with a one-cycle o_done.
// Config: i_cfg_we, i_cfg_index (0 limit, 1 gain), i_cfg_data, only while
// idle. Corners live in one single-port memory of MAX_CORNERS words.
// Steps after the accept edge, N = corner count after the op:
//   search over N entries: read, then distance/compare
//   decide: reread of the best entry when matched
//   update pass (matched): read, multiply, add/clamp, write back per entry
//   centroid: read per entry, then x and y divides,
//             each started in S_CDIV and awaited in S_CWAIT on the 16-step divider
//   output: o_done is high in the cycle after it
// A matched event runs every step, an unmatched event skips the update pass, append or
// unused op runs centroid (skipped on an empty table) and output, clear or empty-table event output only.
// One command at a time; the next may be taken in the o_done cycle.
// Reset: count zero, registers to defaults; corner contents are not
// cleared (entries past count are never read). The receiver cannot
// stall: o_done is a one-cycle pulse.
module event_corner_tracker_unit #(
    parameter int unsigned MAX_CORNERS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [1:0]  i_op,
    input  wire  [9:0]  i_pos_x,
    input  wire  [9:0]  i_pos_y,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [19:0] i_cfg_data,
    output logic        o_done,
    output logic        o_matched,
    output logic [3:0]  o_match_index,
    output logic [9:0]  o_center_x,
    output logic [9:0]  o_center_y,
    output logic [4:0]  o_corner_count,
    output logic        o_table_full
);
    `include "event_corner_tracker_unit_defines.svh"

    localparam int unsigned AW = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
    localparam int unsigned CNTW = $clog2(MAX_CORNERS + 1);
    localparam int unsigned CW = ect_pkg::CoordW;

    typedef enum logic [3:0] {
        S_IDLE, S_SRD, S_SCMP, S_DECIDE, S_URD, S_UMUL, S_UADD, S_UWR,
        S_CRD, S_CDIV, S_CWAIT, S_OUT
    } t_state;

    t_state r_state;
    logic [19:0] r_limit;
    logic [15:0] r_gain;
    logic [CNTW-1:0] r_count;
    ect_pkg::t_coord r_px, r_py;
    logic [AW-1:0] r_idx;
    logic [CNTW-1:0] r_iter;
    logic [ect_pkg::SqW-1:0] r_best;
    logic [AW-1:0] r_bi;
    logic r_rd_pend;
    logic signed [CW:0] r_ddx, r_ddy;
    logic signed [27:0] r_px_prod, r_py_prod;
    ect_pkg::t_coord r_nx, r_ny;
    logic r_matched, r_full, r_axis;
    logic [CW+4:0] r_sum_x, r_sum_y;
    ect_pkg::t_coord r_cur_x, r_cur_y;

    logic mem_we;
    logic [AW-1:0] mem_addr;
    logic [2*CW-1:0] mem_wdata, mem_rdata;
    ect_pkg::t_coord rd_x, rd_y;

    ect_pkg::t_div_req div_req;
    logic div_done;
    logic [15:0] div_quot;

    assign rd_x = mem_rdata[2*CW-1:CW];
    assign rd_y = mem_rdata[CW-1:0];

    ect_corner_mem #(.DEPTH(MAX_CORNERS), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wdata), .o_rdata(mem_rdata)
    );

    ect_divider #(.W(16)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_req.start),
        .i_dividend(div_req.dividend), .i_divisor(div_req.divisor),
        .o_done(div_done), .o_quot(div_quot)
    );

    // squared distance of the word just read
    logic signed [CW:0] dx, dy;
    logic [ect_pkg::SqW-1:0] dsq;
    always_comb begin
        dx  = $signed({1'b0, rd_x}) - $signed({1'b0, r_px});
        dy  = $signed({1'b0, rd_y}) - $signed({1'b0, r_py});
        dsq = ect_pkg::SqW'(dx * dx) + ect_pkg::SqW'(dy * dy);
    end

    // shift: old*65536 + gain*delta, truncate, clamp
    function automatic ect_pkg::t_coord clamp_q(input logic [CW-1:0] old,
                                                 input logic signed [27:0] prod);
        logic signed [28:0] s;
        begin
            s = $signed({3'b0, old, 16'b0}) + 29'(prod);
            if (s < 0) clamp_q = '0;
            else if (s[28:16] > 13'(ect_pkg::COORD_MAX)) clamp_q = ect_pkg::COORD_MAX;
            else clamp_q = s[25:16];
        end
    endfunction

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_idx;
        mem_wdata = {r_nx, r_ny};
        if (r_state == S_IDLE) begin
            mem_addr  = r_count[AW-1:0];
            mem_wdata = {i_pos_x, i_pos_y};
            mem_we = i_start && (i_op == ect_pkg::OP_APPEND)
                     && (r_count < CNTW'(MAX_CORNERS));
        end else if (r_state == S_UWR) begin
            mem_we = 1'b1;
        end
        div_req.start    = (r_state == S_CDIV);
        div_req.dividend = 16'(r_axis ? r_cur_y : r_cur_x);
        div_req.divisor  = 16'(r_count);
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= 20'd400;
            r_gain  <= 16'd32768;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ect_pkg::REG_LIMIT: r_limit <= i_cfg_data;
                    ect_pkg::REG_GAIN:  r_gain  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_px <= i_pos_x; r_py <= i_pos_y;
                        r_matched <= 1'b0; r_full <= 1'b0;
                        r_idx <= '0; r_iter <= '0;
                        r_best <= ect_pkg::SEARCH_START_SQ; r_bi <= '0;
                        r_sum_x <= '0; r_sum_y <= '0;
                        r_rd_pend <= 1'b0;
                        case (i_op)
                            ect_pkg::OP_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_OUT;
                            end
                            ect_pkg::OP_APPEND: begin
                                if (r_count < CNTW'(MAX_CORNERS)) r_count <= r_count + 1'b1;
                                else r_full <= 1'b1;
                                r_state <= S_CRD;
                            end
                            ect_pkg::OP_EVENT: r_state <= (r_count == '0) ? S_OUT : S_SRD;
                            default: r_state <= S_CRD;
                        endcase
                    end
                end
                S_SRD: r_state <= S_SCMP;
                S_SCMP: begin
                    if (dsq < r_best) begin
                        r_best <= dsq; r_bi <= r_idx;
                    end
                    if (r_iter + 1'b1 == r_count) begin
                        r_state <= S_DECIDE;
                        r_idx <= r_bi;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_DECIDE: begin
                    // r_idx = best index: read it for the deltas
                    if (!r_rd_pend) begin
                        r_idx <= r_bi;
                        if (r_best < {1'b0, r_limit}) r_rd_pend <= 1'b1;
                        else begin
                            r_idx <= '0; r_iter <= '0; r_state <= S_CRD;
                        end
                    end else if (r_rd_pend && r_iter != '1) begin
                        r_iter <= '1; // wait for the registered read data
                    end else begin
                        r_ddx <= $signed({1'b0, r_px}) - $signed({1'b0, rd_x});
                        r_ddy <= $signed({1'b0, r_py}) - $signed({1'b0, rd_y});
                        r_matched <= 1'b1;
                        r_idx <= '0; r_iter <= '0;
                        r_rd_pend <= 1'b0;
                        r_state <= S_URD;
                    end
                end
                S_URD: r_state <= S_UMUL;
                S_UMUL: begin
                    r_cur_x <= rd_x; r_cur_y <= rd_y;
                    r_px_prod <= $signed({1'b0, r_gain}) * r_ddx;
                    r_py_prod <= $signed({1'b0, r_gain}) * r_ddy;
                    r_state <= S_UADD;
                end
                S_UADD: begin
                    r_nx <= clamp_q(r_cur_x, r_px_prod);
                    r_ny <= clamp_q(r_cur_y, r_py_prod);
                    r_state <= S_UWR;
                end
                S_UWR: begin
                    if (r_iter + 1'b1 == r_count) begin
                        r_idx <= '0; r_iter <= '0; r_state <= S_CRD;
                    end else begin
                        r_iter <= r_iter + 1'b1; r_idx <= r_idx + 1'b1;
                        r_state <= S_URD;
                    end
                end
                S_CRD: begin
                    if (r_count == '0) r_state <= S_OUT;
                    else if (!r_rd_pend) r_rd_pend <= 1'b1;
                    else begin
                        r_rd_pend <= 1'b0;
                        r_axis <= 1'b0;
                        r_cur_x <= rd_x; r_cur_y <= rd_y;
                        r_state <= S_CDIV;
                    end
                end
                S_CDIV: r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (div_done) begin
                        if (!r_axis) begin
                            r_sum_x <= r_sum_x + (CW+5)'(div_quot);
                            r_axis <= 1'b1;
                            r_state <= S_CDIV;
                        end else begin
                            r_sum_y <= r_sum_y + (CW+5)'(div_quot);
                            if (r_iter + 1'b1 == r_count) r_state <= S_OUT;
                            else begin
                                r_iter <= r_iter + 1'b1; r_idx <= r_idx + 1'b1;
                                r_state <= S_CRD;
                            end
                        end
                    end
                end
                S_OUT: begin
                    o_done <= 1'b1;
                    o_matched <= r_matched;
                    o_match_index <= r_matched ? 4'(r_bi) : 4'd0;
                    o_center_x <= r_sum_x[CW-1:0];
                    o_center_y <= r_sum_y[CW-1:0];
                    o_corner_count <= 5'(r_count);
                    o_table_full <= r_full;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ECT_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNTW'(MAX_CORNERS), "count overflow")
    `ECT_ASSERT(a_done_from_out, i_clk, i_rst_n, o_done |-> $past(r_state == S_OUT), "done without output state")
    `ECT_ASSERT(a_no_write_busy_idle, i_clk, i_rst_n, (mem_we && r_state == S_IDLE) |-> i_start, "stray write")
    `ECT_ASSERT(a_match_limit, i_clk, i_rst_n, (o_done && o_matched) |-> o_corner_count != 5'd0, "match on empty table")
endmodule
`default_nettype wire

// ===== hw/rtl/ect_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module ect_divider #(
    parameter int unsigned W = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire [W-1:0]  i_dividend,
    input  wire [W-1:0]  i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot
);
    localparam int unsigned CW = $clog2(W + 1);
    logic [W-1:0] r_rem, r_quot, r_dvs;
    logic [CW-1:0] r_cnt;
    logic r_busy;
    logic [W:0] n_trial;
    logic [W-1:0] n_rem;

    always_comb begin
        n_rem   = {r_rem[W-2:0], r_quot[W-1]};
        n_trial = {1'b0, n_rem} - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_dvs  <= i_divisor;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                if (n_trial[W]) begin
                    r_rem <= n_rem;
                    r_quot <= {r_quot[W-2:0], 1'b0};
                end else begin
                    r_rem <= n_trial[W-1:0];
                    r_quot <= {r_quot[W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
endmodule
`default_nettype wire

// ===== hw/rtl/ect_corner_mem.sv =====
`default_nettype none
// Corner store: x and y packed in one word, one port, registered read.
module ect_corner_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW = 4
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire [AW-1:0]                 i_addr,
    input  wire [2*ect_pkg::CoordW-1:0]  i_wdata,
    output logic [2*ect_pkg::CoordW-1:0] o_rdata
);
    logic [2*ect_pkg::CoordW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== test/event_corner_tracker_unit_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module event_corner_tracker_unit_test;

    localparam int MaxCorners = 16;
    localparam int CycleLimit = 10000000;
    localparam logic [1:0] OpUnused = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] px;
        logic [9:0] py;
    } t_cmd_word;

    typedef struct packed {
        logic       matched;
        logic [3:0] idx;
        logic [9:0] cx;
        logic [9:0] cy;
        logic [4:0] cnt;
        logic       full;
    } t_track_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_op = '0;
    logic [9:0]  i_pos_x = '0;
    logic [9:0]  i_pos_y = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [19:0] i_cfg_data = '0;
    wire         o_busy, o_done, o_matched, o_table_full;
    wire  [3:0]  o_match_index;
    wire  [9:0]  o_center_x, o_center_y;
    wire  [4:0]  o_corner_count;

    event_corner_tracker_unit #(.MAX_CORNERS(MaxCorners)) uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state: corner table, count and registers
    logic [9:0]  trk_x [MaxCorners];
    logic [9:0]  trk_y [MaxCorners];
    int          trk_count;
    logic [19:0] trk_limit;
    logic [15:0] trk_gain;

    t_cmd_word   cmd_queue[$];
    t_track_word expected_words[$];
    int          errors = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    int          gap = 0;
    bit          in_flight = 1'b0;

    // old + gain*delta in Q16, truncated, clamped to coordinate range
    function automatic logic [9:0] shift_coord(logic [9:0] old, int delta);
        longint s;
        s = longint'(old) * 65536 + longint'(trk_gain) * longint'(delta);
        if (s < 0) return '0;
        s = s >>> 16;
        return (s > 1023) ? ect_pkg::COORD_MAX : 10'(s);
    endfunction

    function automatic t_track_word track_step(t_cmd_word c);
        t_track_word r;
        int best, bi, dx, dy, d, ddx, ddy, sx, sy;
        r = '0;
        if (c.op == ect_pkg::OP_CLEAR) begin
            trk_count = 0;
        end else if (c.op == ect_pkg::OP_APPEND) begin
            if (trk_count < MaxCorners) begin
                trk_x[trk_count] = c.px;
                trk_y[trk_count] = c.py;
                trk_count++;
            end else begin
                r.full = 1'b1;
            end
        end else if (c.op == ect_pkg::OP_EVENT && trk_count > 0) begin
            best = int'(ect_pkg::SEARCH_START_SQ);
            bi = 0;
            for (int i = 0; i < trk_count; i++) begin
                dx = int'(trk_x[i]) - int'(c.px);
                dy = int'(trk_y[i]) - int'(c.py);
                d = dx * dx + dy * dy;
                if (d < best) begin
                    best = d;
                    bi = i;
                end
            end
            if (best < int'(trk_limit)) begin
                ddx = int'(c.px) - int'(trk_x[bi]);
                ddy = int'(c.py) - int'(trk_y[bi]);
                for (int i = 0; i < trk_count; i++) begin
                    trk_x[i] = shift_coord(trk_x[i], ddx);
                    trk_y[i] = shift_coord(trk_y[i], ddy);
                end
                r.matched = 1'b1;
                r.idx = 4'(bi);
            end
        end
        sx = 0;
        sy = 0;
        for (int i = 0; i < trk_count; i++) begin
            sx += int'(trk_x[i]) / trk_count;
            sy += int'(trk_y[i]) / trk_count;
        end
        r.cx = 10'(sx);
        r.cy = 10'(sy);
        r.cnt = 5'(trk_count);
        return r;
    endfunction

    function automatic void add_cmd(t_cmd_word c);
        cmd_queue.insert(cmd_queue.size(), c);
    endfunction

    // driver: pops one word per accepted command, bursts of idle between
    always @(posedge i_clk) begin
        t_track_word w;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                w = track_step(cmd_queue.pop_front());
                expected_words.insert(expected_words.size(), w);
                in_flight = 1'b0;
            end
            if (in_flight) begin
                // keep holding the current word
            end else if (gap > 0) begin
                gap = gap - 1;
                i_start <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 17);
                i_start <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                i_op <= cmd_queue[0].op;
                i_pos_x <= cmd_queue[0].px;
                i_pos_y <= cmd_queue[0].py;
                i_start <= 1'b1;
                in_flight = 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: one result word per o_done pulse
    always @(posedge i_clk) begin
        t_track_word got, want;
        if (i_rst_n && o_done) begin
            got = {o_matched, o_match_index, o_center_x, o_center_y,
                   o_corner_count, o_table_full};
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp m%0d i%0d c%0d,%0d n%0d f%0d",
                                  " got m%0d i%0d c%0d,%0d n%0d f%0d"},
                                 want.matched, want.idx, want.cx, want.cy,
                                 want.cnt, want.full,
                                 got.matched, got.idx, got.cx, got.cy,
                                 got.cnt, got.full);
                end
            end
        end
    end

    function automatic t_cmd_word mk(logic [1:0] op, int x, int y);
        return '{op: op, px: 10'(x), py: 10'(y)};
    endfunction

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || in_flight || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [19:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ect_pkg::REG_LIMIT) trk_limit = value;
        else trk_gain = value[15:0];
    endtask

    // burst: clear, 1-5 or 10-17 appends, random ops, near events
    task automatic queue_track_burst(int n_ev);
        int n, k, bx, by;
        add_cmd(mk(ect_pkg::OP_CLEAR, $urandom, $urandom));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 17) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
            add_cmd(mk(ect_pkg::OP_APPEND, $urandom_range(0, 1023), $urandom_range(0, 1023)));
        for (int i = 0; i < n_ev; i++) begin
            k = $urandom_range(0, 3);
            if (k == 0) begin
                add_cmd(mk(ect_pkg::OP_EVENT, $urandom_range(0, 1023),
                           $urandom_range(0, 1023)));
            end else if (k == 1) begin
                add_cmd(mk(2'($urandom_range(0, 3)), $urandom, $urandom));
            end else begin
                // near positions taken from the last two queued commands
                bx = $urandom_range(0, 1023);
                by = $urandom_range(0, 1023);
                if (cmd_queue.size() > 1) begin
                    bx = cmd_queue[cmd_queue.size() - 1 - $urandom_range(0, 1)].px;
                    by = cmd_queue[cmd_queue.size() - 1 - $urandom_range(0, 1)].py;
                end
                bx += $urandom_range(0, 30) - 15;
                by += $urandom_range(0, 30) - 15;
                add_cmd(mk(ect_pkg::OP_EVENT, (bx < 0) ? 0 : (bx > 1023 ? 1023 : bx),
                           (by < 0) ? 0 : (by > 1023 ? 1023 : by)));
            end
        end
    endtask

    initial begin
        int total;
        int sz;
        trk_count = 0;
        trk_limit = 20'd400;
        trk_gain = 16'd32768;
        for (int i = 0; i < MaxCorners; i++) begin
            trk_x[i] = '0;
            trk_y[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, unused op, far event, full table
        add_cmd(mk(ect_pkg::OP_EVENT, 5, 5));
        add_cmd(mk(OpUnused, 1023, 1023));
        add_cmd(mk(ect_pkg::OP_APPEND, 0, 0));
        add_cmd(mk(ect_pkg::OP_APPEND, 1023, 1023));
        add_cmd(mk(ect_pkg::OP_EVENT, 1, 1));
        add_cmd(mk(ect_pkg::OP_EVENT, 1020, 1022));
        add_cmd(mk(ect_pkg::OP_EVENT, 512, 512));
        add_cmd(mk(OpUnused, 0, 0));
        for (int i = 0; i < 15; i++)
            add_cmd(mk(ect_pkg::OP_APPEND, i * 60, 1000 - i * 60));
        add_cmd(mk(ect_pkg::OP_EVENT, 62, 938));
        wait_drained();

        // far event accepted: limit at max, gain at max
        write_reg(ect_pkg::REG_LIMIT, 20'hFFFFF);
        write_reg(ect_pkg::REG_GAIN, 20'hFFFF);
        add_cmd(mk(ect_pkg::OP_CLEAR, 0, 0));
        add_cmd(mk(ect_pkg::OP_APPEND, 0, 0));
        add_cmd(mk(ect_pkg::OP_EVENT, 1023, 1023));
        add_cmd(mk(ect_pkg::OP_APPEND, 1023, 0));
        add_cmd(mk(ect_pkg::OP_EVENT, 0, 1023));
        wait_drained();

        // random phases across register settings
        total = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin
                    write_reg(ect_pkg::REG_LIMIT, 20'd0);
                    write_reg(ect_pkg::REG_GAIN, 20'd0);
                end
                1: begin
                    write_reg(ect_pkg::REG_LIMIT, 20'd400);
                    write_reg(ect_pkg::REG_GAIN, 20'd32768);
                end
                2: write_reg(ect_pkg::REG_LIMIT, 20'($urandom_range(0, 20000)));
                default: begin
                    write_reg(ect_pkg::REG_LIMIT, 20'($urandom));
                    write_reg(ect_pkg::REG_GAIN, 20'($urandom_range(0, 65535)));
                end
            endcase
            if (ph == 7) idle_on = 1'b0;
            while (total < (ph + 1) * 250) begin
                sz = cmd_queue.size();
                queue_track_burst($urandom_range(2, 12));
                total = total + (cmd_queue.size() - sz);
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
